### hdl/grs_pkg.sv
package grs_pkg;

	localparam int POP_WIDTH_DEF      = 20;
	localparam int TIME_FRAC_BITS_DEF = 24;

	localparam logic [23:0] LN2_Q24 = 24'd11629080;

	// Register indexes on the configuration port.
	localparam logic [2:0] CFG_MUTANT_COST   = 3'd0;
	localparam logic [2:0] CFG_DEATH_EXCESS  = 3'd1;
	localparam logic [2:0] CFG_MUTATION_PROB = 3'd2;
	localparam logic [2:0] CFG_DEATH_FACTOR  = 3'd3;
	localparam logic [2:0] CFG_PHASE1_TARGET = 3'd4;
	localparam logic [2:0] CFG_RESCUE_TARGET = 3'd5;
	localparam logic [2:0] CFG_INITIAL_WILD  = 3'd6;

	localparam logic [31:0] RST_MUTANT_COST   = 32'd858993459;
	localparam logic [31:0] RST_DEATH_EXCESS  = 32'd0;
	localparam logic [31:0] RST_MUTATION_PROB = 32'd8590;
	localparam logic [31:0] RST_DEATH_FACTOR  = 32'd0;
	localparam logic [19:0] RST_PHASE1_TARGET = 20'd10000;
	localparam logic [19:0] RST_RESCUE_TARGET = 20'd11000;
	localparam logic [19:0] RST_INITIAL_WILD  = 20'd1;

	// Event codes.
	localparam logic [2:0] KIND_WT_BIRTH  = 3'd0;
	localparam logic [2:0] KIND_WT_DEATH  = 3'd1;
	localparam logic [2:0] KIND_MUTATION  = 3'd2;
	localparam logic [2:0] KIND_MT_BIRTH  = 3'd3;
	localparam logic [2:0] KIND_MT_DEATH  = 3'd4;
	localparam logic [2:0] KIND_NONE      = 3'd5;

	// ln(1 + 2^-k) in Q.24, rounded.
	function automatic logic [22:0] ln_tab(input logic [4:0] k);
		logic [22:0] v;
		case (k)
			5'd1:  v = 23'd6802576;
			5'd2:  v = 23'd3743728;
			5'd3:  v = 23'd1976071;
			5'd4:  v = 23'd1017112;
			5'd5:  v = 23'd516263;
			5'd6:  v = 23'd260117;
			5'd7:  v = 23'd130563;
			5'd8:  v = 23'd65408;
			5'd9:  v = 23'd32736;
			5'd10: v = 23'd16376;
			5'd11: v = 23'd8190;
			5'd12: v = 23'd4096;
			5'd13: v = 23'd2048;
			5'd14: v = 23'd1024;
			5'd15: v = 23'd512;
			5'd16: v = 23'd256;
			5'd17: v = 23'd128;
			5'd18: v = 23'd64;
			5'd19: v = 23'd32;
			5'd20: v = 23'd16;
			5'd21: v = 23'd8;
			5'd22: v = 23'd4;
			5'd23: v = 23'd2;
			5'd24: v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

### hdl/gillespie_rescue_step.sv
// Channel   Dir  Handshake                     Content
// s_axis    in   s_axis_tvalid/s_axis_tready   two uniform fractions per event
// m_axis    out  m_axis_tvalid/m_axis_tready   population, time and outcome
// cfg       in   cfg_valid/cfg_ready           register index and write data
//
// An item with an event passes from its input transfer to its result through the rate
// products and target, the event pick, normalization of the time draw, 24 log steps, a
// division setup, 64 division steps (skipped when the quotient saturates), apply and finish.
// An item without an event goes straight to finish; a zero total rate ends after the rate products.
// arst_n clears all control state and loads the register defaults.
// Input is taken only while the sequencer is idle; a result waiting on a stalled
// m_axis holds the sequencer in its final state until the transfer happens.
module gillespie_rescue_step #(
	parameter int POP_WIDTH      = grs_pkg::POP_WIDTH_DEF,
	parameter int TIME_FRAC_BITS = grs_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] uniform_time, [63:32] uniform_pick
	input  logic [63:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [19:0] wild_count, [39:20] mutant_count, [103:40] elapsed_time,
	// [104] rescued, [124:105] growth_end_mutants, [127:125] zero
	output logic [127:0] m_axis_tdata,
	// [0] phase_now, [3:1] event_kind
	output logic [3:0]   m_axis_tuser,
	// run_done
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import grs_pkg::*;

	// Wide populations drop low coefficient bits so every weight fits 64 bits.
	localparam int RATE_DROP = (POP_WIDTH > 28) ? POP_WIDTH - 28 : 0;
	localparam int CW        = 33 - RATE_DROP;
	localparam int WW        = CW + POP_WIDTH;
	localparam int AW        = WW + 3;
	localparam int DT_SHIFT  = TIME_FRAC_BITS + 10 - RATE_DROP;
	localparam logic [POP_WIDTH-1:0] POP_MAX = {POP_WIDTH{1'b1}};

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_PICK  = 4'd2;
	localparam logic [3:0] S_NORM  = 4'd3;
	localparam logic [3:0] S_LOG   = 4'd4;
	localparam logic [3:0] S_DSET  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_APPLY = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	// Configuration registers.
	logic [31:0] s1_q, s2_q, u_q, delta_q;
	logic [19:0] p1_q, rt_q, iw_q;

	// Simulation state.
	logic [POP_WIDTH-1:0] x_q, y_q, mas_q;
	logic [63:0]          time_q;
	logic                 treat_q;

	// Sequencer and datapath registers.
	logic [3:0]    state_q;
	logic [3:0]    step_q;
	logic          evt_q;
	logic [2:0]    kind_q;
	logic [31:0]   r2_q;
	logic [31:0]   ds_q;
	logic [32:0]   c4_q;
	logic [WW-1:0] w_q [5];
	logic [AW-1:0] a0_q, cum_q;
	logic [63:0]   tg_q;
	logic [2:0]    pi_q;
	logic [31:0]   m_q;
	logic [28:0]   whole_q;
	logic [31:0]   acc_q;
	logic [24:0]   ylog_q;
	logic [4:0]    k_q;
	logic [63:0]   rem_q, lo_q, q_q;
	logic [5:0]    cnt_q;

	// Output register.
	logic         out_valid_q;
	logic [127:0] out_data_q;
	logic [3:0]   out_user_q;
	logic         out_last_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	logic in_xfer;
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// Start count for a fresh run, saturated to the population width.
	logic [POP_WIDTH-1:0] start_cnt;
	assign start_cnt = (33'(iw_q) > 33'(POP_MAX)) ? POP_MAX : POP_WIDTH'(iw_q);

	// Wild-type and mutant birth coefficients.
	logic [32:0] c0_full, c3_full;
	assign c0_full = 33'h1_0000_0000 - {1'b0, u_q};
	assign c3_full = 33'h1_0000_0000 - {1'b0, s1_q};

	logic [2:0] wi, ai;
	assign wi = 3'(step_q - 4'd2);
	assign ai = 3'(step_q - 4'd3);

	// The shared multiplier; its product always lands in a register.
	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic [64:0] prod;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			4'd0: begin
				mul_a = {1'b0, delta_q};
				mul_b = s2_q;
			end
			4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
				case (wi)
					3'd0:    mul_a = 33'(c0_full[32:RATE_DROP]);
					3'd1:    mul_a = 33'(delta_q[31:RATE_DROP]);
					3'd2:    mul_a = 33'(u_q[31:RATE_DROP]);
					3'd3:    mul_a = 33'(c3_full[32:RATE_DROP]);
					default: mul_a = 33'(c4_q[32:RATE_DROP]);
				endcase
				mul_b = (wi < 3'd3) ? 32'(x_q) : 32'(y_q);
			end
			4'd8: begin
				mul_a = 33'(a0_q[AW-1:32]);
				mul_b = r2_q;
			end
			4'd9: begin
				mul_a = {1'b0, a0_q[31:0]};
				mul_b = r2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// Event pick: one weight per cycle against the scaled target.
	logic [AW-1:0] cum_n;
	assign cum_n = cum_q + AW'(w_q[pi_q]);

	// Shift-add log step.
	logic [32:0] log_t;
	assign log_t = {1'b0, acc_q} + {1'b0, acc_q >> k_q};

	// Division setup: -ln(r1) scaled up to the time fraction.
	logic [28:0]  l_w;
	logic [127:0] num_w;
	assign l_w   = (whole_q > 29'(ylog_q)) ? whole_q - 29'(ylog_q) : 29'd0;
	assign num_w = 128'(l_w) << DT_SHIFT;

	// One restoring division step.
	logic [63:0] div_sh, div_d;
	logic        div_bit;
	assign div_sh  = {rem_q[62:0], lo_q[63]};
	assign div_d   = 64'(a0_q);
	assign div_bit = rem_q[63] || (div_sh >= div_d);

	logic [64:0] tsum;
	assign tsum = {1'b0, time_q} + {1'b0, q_q};

	// Precheck at the start of an item.
	logic pre_skip;
	always_comb begin
		if (!treat_q) begin
			pre_skip = ((x_q == '0) && (y_q == '0)) || ((33'(x_q) + 33'(y_q)) >= 33'(p1_q));
		end else begin
			pre_skip = (y_q == '0) || (33'(y_q) >= 33'(rt_q));
		end
	end

	// Outcome of the item once the event, if any, has been applied.
	logic [POP_WIDTH-1:0] f_x, f_y, f_mas;
	logic [63:0]          f_time;
	logic                 f_treat, f_done, f_resc, f_sw, ev_zero;
	logic [2:0]           f_kind;
	always_comb begin
		f_x     = x_q;
		f_y     = y_q;
		f_mas   = mas_q;
		f_time  = time_q;
		f_treat = treat_q;
		f_done  = 1'b0;
		f_resc  = 1'b0;
		f_sw    = 1'b0;
		f_kind  = evt_q ? kind_q : KIND_NONE;
		ev_zero = evt_q && (kind_q == KIND_NONE);
		if (!treat_q) begin
			if (ev_zero) begin
				f_done = 1'b1;
			end else if (evt_q) begin
				// Extinction in the growth phase restarts it.
				if ((x_q == '0) && (y_q == '0)) begin
					f_x = start_cnt;
					f_y = '0;
				end
				f_sw = (33'(f_x) + 33'(f_y)) >= 33'(p1_q);
			end else begin
				f_sw = 1'b1;
			end
			if (f_sw) begin
				f_mas   = f_y;
				f_x     = '0;
				f_time  = '0;
				f_treat = 1'b1;
				if ((f_y == '0) || (33'(f_y) >= 33'(rt_q))) begin
					f_done = 1'b1;
					f_resc = 33'(f_y) >= 33'(rt_q);
				end
			end
		end else begin
			if (ev_zero) begin
				f_done = 1'b1;
			end else if ((y_q == '0) || (33'(y_q) >= 33'(rt_q))) begin
				f_done = 1'b1;
				f_resc = 33'(y_q) >= 33'(rt_q);
			end
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q    <= RST_MUTANT_COST;
			s2_q    <= RST_DEATH_EXCESS;
			u_q     <= RST_MUTATION_PROB;
			delta_q <= RST_DEATH_FACTOR;
			p1_q    <= RST_PHASE1_TARGET;
			rt_q    <= RST_RESCUE_TARGET;
			iw_q    <= RST_INITIAL_WILD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MUTANT_COST:   s1_q    <= cfg_data;
				CFG_DEATH_EXCESS:  s2_q    <= cfg_data;
				CFG_MUTATION_PROB: u_q     <= cfg_data;
				CFG_DEATH_FACTOR:  delta_q <= cfg_data;
				CFG_PHASE1_TARGET: p1_q    <= cfg_data[19:0];
				CFG_RESCUE_TARGET: rt_q    <= cfg_data[19:0];
				CFG_INITIAL_WILD:  iw_q    <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_data_q <= {3'b0, 20'(f_mas), f_resc, f_time, 20'(f_y), 20'(f_x)};
			out_user_q <= {f_kind, f_treat};
			out_last_q <= f_done;
		end
	end

	// Simulation state and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q     <= POP_WIDTH'(RST_INITIAL_WILD);
			y_q     <= '0;
			mas_q   <= '0;
			time_q  <= '0;
			treat_q <= 1'b0;
			step_q  <= '0;
			evt_q   <= 1'b0;
			kind_q  <= KIND_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						step_q <= '0;
						evt_q  <= !pre_skip;
						kind_q <= KIND_NONE;
						state_q <= pre_skip ? S_FIN : S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd8 && a0_q == '0) begin
						// Zero total rate: no event, no time step.
						kind_q  <= KIND_NONE;
						state_q <= S_FIN;
					end else if (step_q == 4'd9) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (w_q[pi_q] != '0 && 64'(cum_n) >= tg_q) begin
						kind_q  <= pi_q;
						state_q <= S_NORM;
					end else if (pi_q == 3'd4) begin
						kind_q  <= KIND_MT_DEATH;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (m_q[31]) begin
						state_q <= S_LOG;
					end
				end
				S_LOG: begin
					if (k_q == 5'd24) begin
						state_q <= S_DSET;
					end
				end
				S_DSET: begin
					state_q <= (num_w[127:64] >= div_d) ? S_APPLY : S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 6'd0) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					time_q <= tsum[64] ? {64{1'b1}} : tsum[63:0];
					case (kind_q)
						KIND_WT_BIRTH: if (x_q != POP_MAX) x_q <= x_q + POP_WIDTH'(1);
						KIND_WT_DEATH: if (x_q != '0) x_q <= x_q - POP_WIDTH'(1);
						KIND_MUTATION, KIND_MT_BIRTH: if (y_q != POP_MAX) y_q <= y_q + POP_WIDTH'(1);
						default: if (y_q != '0) y_q <= y_q - POP_WIDTH'(1);
					endcase
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						if (f_done) begin
							x_q     <= start_cnt;
							y_q     <= '0;
							time_q  <= '0;
							treat_q <= 1'b0;
							mas_q   <= '0;
						end else begin
							x_q     <= f_x;
							y_q     <= f_y;
							time_q  <= f_time;
							treat_q <= f_treat;
							mas_q   <= f_mas;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; their contents only matter inside an item.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				r2_q    <= s_axis_tdata[63:32];
				m_q     <= (s_axis_tdata[31:0] == 32'd0) ? 32'd1 : s_axis_tdata[31:0];
				whole_q <= 29'(LN2_Q24);
				a0_q    <= '0;
				cum_q   <= '0;
				pi_q    <= '0;
			end
			S_MUL: begin
				case (step_q)
					4'd0: ds_q <= prod[63:32];
					4'd1: c4_q <= {1'b0, delta_q} + {1'b0, ds_q};
					4'd8: tg_q <= prod[63:0];
					4'd9: tg_q <= tg_q + {32'd0, prod[63:32]};
					default: ;
				endcase
				if (step_q >= 4'd2 && step_q <= 4'd6) begin
					w_q[wi] <= prod[WW-1:0];
				end
				if (step_q >= 4'd3 && step_q <= 4'd7) begin
					a0_q <= a0_q + AW'(w_q[ai]);
				end
			end
			S_PICK: begin
				cum_q <= cum_n;
				pi_q  <= pi_q + 3'd1;
			end
			S_NORM: begin
				if (m_q[31]) begin
					acc_q  <= 32'h8000_0000;
					ylog_q <= '0;
					k_q    <= 5'd1;
				end else begin
					m_q     <= {m_q[30:0], 1'b0};
					whole_q <= whole_q + 29'(LN2_Q24);
				end
			end
			S_LOG: begin
				if (log_t <= {1'b0, m_q}) begin
					acc_q  <= log_t[31:0];
					ylog_q <= ylog_q + 25'(ln_tab(k_q));
				end
				k_q <= k_q + 5'd1;
			end
			S_DSET: begin
				rem_q <= num_w[127:64];
				lo_q  <= num_w[63:0];
				q_q   <= (num_w[127:64] >= div_d) ? {64{1'b1}} : 64'd0;
				cnt_q <= 6'd63;
			end
			S_DIV: begin
				rem_q <= div_bit ? div_sh - div_d : div_sh;
				lo_q  <= {lo_q[62:0], 1'b0};
				q_q   <= {q_q[62:0], div_bit};
				cnt_q <= cnt_q - 6'd1;
			end
			default: ;
		endcase
	end

endmodule

### hdl/grs_checker.sv
module grs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [3:0]   m_axis_tuser,
	input logic         m_axis_tlast
);
	import grs_pkg::*;

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// A rescue always ends the run.
	a_rescue_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[104] |-> m_axis_tlast)
		else $error("rescue without run end");

	// An item without an event that does not end the run is the phase switch.
	a_none_switch: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[3:1] == KIND_NONE) && !m_axis_tlast
			|-> m_axis_tuser[0])
		else $error("no event outside a phase switch");

	// No wild-type cells in the treatment phase.
	a_treat_wild: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[19:0] == 20'd0))
		else $error("wild-type count in treatment phase");

	// The switch count stays zero during growth.
	a_growth_mas: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[124:105] == 20'd0))
		else $error("switch count set during growth");

endmodule

bind gillespie_rescue_step grs_checker u_grs_checker (.*);
